@@ rtl/pds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg: shared constants for the proper divisor sum block
// Result width and the default input width.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Width of the divisor sum result; sums saturate at its all-ones value.
  localparam int SUM_BITS = 34;

  // Default width of the number under test.
  localparam int NUMBER_BITS_DEF = 31;

endpackage

@@ rtl/proper_divisor_sum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proper_divisor_sum: aliquot sum and perfect number test
// Sums the proper divisors of a number by trial division and flags perfect
// numbers.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                 Direction  Transfer when
//  input     in_valid, in_stall, in_number         in         valid & !stall
//  result    out_valid, out_stall,                 out        valid & !stall
//            out_aliquot_sum, out_perfect_flag
//
//  Trial divisors d = 2, 3, ... run while d <= number / d; each trial is one
//  pass of the serial divider; a found divisor is added in the ADD_D step
//  and its cofactor, if it differs, in the ADD_Q step. Numbers below 2 skip
//  the divider and go from the accepting step straight to the finishing one.
//  Reset is synchronous and active low. in_stall is high from an accepted
//  number until its result is moved to the output register; a result still
//  waiting in the output register delays that move, and no new number may
//  enter meanwhile.
// ----------------------------------------------------------------------------
module proper_divisor_sum
  import pds_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [NUMBER_BITS-1:0] in_number,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SUM_BITS-1:0]    out_aliquot_sum,
  output logic                   out_perfect_flag
);

  localparam int AddW = ((NUMBER_BITS > SUM_BITS) ? NUMBER_BITS : SUM_BITS) + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIVIDE = 3'd1;
  localparam logic [2:0] S_ADD_D  = 3'd2;
  localparam logic [2:0] S_ADD_Q  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [AddW-1:0] SumMax = {{(AddW - SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

  logic [2:0]             state_r;
  logic [2:0]             state_nxt;
  logic [NUMBER_BITS-1:0] n_r;
  logic [NUMBER_BITS-1:0] n_nxt;
  logic [NUMBER_BITS-1:0] d_r;
  logic [NUMBER_BITS-1:0] d_nxt;
  logic [SUM_BITS-1:0]    acc_r;
  logic [SUM_BITS-1:0]    acc_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [SUM_BITS-1:0]    out_sum_r;
  logic [SUM_BITS-1:0]    out_sum_nxt;
  logic                   out_perf_r;
  logic                   out_perf_nxt;

  logic                   in_xfer;
  logic                   div_start;
  logic                   div_done;
  logic [NUMBER_BITS-1:0] div_quo;
  logic [NUMBER_BITS-1:0] div_rem;
  logic [NUMBER_BITS-1:0] add_opnd;
  logic [AddW-1:0]        add_sum;
  logic [SUM_BITS-1:0]    sat_sum;
  logic                   slot_free;
  logic                   perfect;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Shared trial divider: number / d.
  pds_div #(
    .W (NUMBER_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_nxt),
    .divisor   (d_nxt),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Saturating accumulate of either the divisor or its cofactor.
  assign add_opnd = (state_r == S_ADD_Q) ? div_quo : d_r;
  assign add_sum  = {{(AddW - SUM_BITS){1'b0}}, acc_r}
                  + {{(AddW - NUMBER_BITS){1'b0}}, add_opnd};
  assign sat_sum  = (add_sum >= SumMax) ? {SUM_BITS{1'b1}} : add_sum[SUM_BITS-1:0];

  // Perfect when the sum equals a number of at least two.
  assign perfect = (|n_r[NUMBER_BITS-1:1]) &&
                   ({{(AddW - SUM_BITS){1'b0}}, acc_r}
                    == {{(AddW - NUMBER_BITS){1'b0}}, n_r});

  // Sequencer over the trial divisors.
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_sum_nxt   = out_sum_r;
    out_perf_nxt  = out_perf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          n_nxt = in_number;
          d_nxt = NUMBER_BITS'(2);
          if (|in_number[NUMBER_BITS-1:1]) begin
            acc_nxt   = SUM_BITS'(1);
            div_start = 1'b1;
            state_nxt = S_DIVIDE;
          end else begin
            acc_nxt   = '0;
            state_nxt = S_FINISH;
          end
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          if (d_r > div_quo) begin
            state_nxt = S_FINISH;
          end else if (div_rem == '0) begin
            state_nxt = S_ADD_D;
          end else begin
            d_nxt     = d_r + 1'b1;
            div_start = 1'b1;
          end
        end
      end
      S_ADD_D: begin
        acc_nxt = sat_sum;
        if (div_quo != d_r) begin
          state_nxt = S_ADD_Q;
        end else begin
          d_nxt     = d_r + 1'b1;
          div_start = 1'b1;
          state_nxt = S_DIVIDE;
        end
      end
      S_ADD_Q: begin
        acc_nxt   = sat_sum;
        d_nxt     = d_r + 1'b1;
        div_start = 1'b1;
        state_nxt = S_DIVIDE;
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          out_perf_nxt  = perfect;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
    out_perf_r <= out_perf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_aliquot_sum  = out_sum_r;
  assign out_perfect_flag = out_perf_r;

  // The divider only finishes while the sequencer waits for it.
  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVIDE)
    else $error("divider finished outside the divide step");

  // A divisor is only added when it divides the number exactly.
  a_add_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_D) |-> (div_rem == '0) && (d_r <= div_quo))
    else $error("divisor added without an exact division");

  // The cofactor is only added when it differs from the divisor.
  a_cofactor_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD_Q) |-> (div_quo != d_r))
    else $error("cofactor added twice");

  // A result is only loaded from the finishing step.
  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FINISH)
    else $error("result loaded outside the finishing step");

endmodule

@@ rtl/pds_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_div: serial restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold until the
// next start.
// ----------------------------------------------------------------------------
module pds_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] cnt_nxt;
  logic            done_r;
  logic            done_nxt;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    quo_nxt;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    rem_nxt;
  logic [W-1:0]    dsr_r;
  logic [W-1:0]    dsr_nxt;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = ~diff[W];

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      cnt_nxt = CntW'(W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CntW'(1));
      quo_nxt  = {quo_r[W-2:0], fits};
      rem_nxt  = fits ? diff[W-1:0] : trial[W-1:0];
    end
  end

  // Control state is reset; the datapath registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // A finished division always comes from a running count.
  a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r) == CntW'(1))
    else $error("divider done without a final step");

  // A start loads the full step count.
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == CntW'(W))
    else $error("divider start did not load the step count");

  // The partial remainder stays below the divisor while stepping.
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (dsr_r != '0) |-> rem_r < dsr_r)
    else $error("partial remainder out of range");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the proper divisor sum block
// Sends numbers through the valid/stall input channel and checks every
// divisor sum and perfect flag against a trial-division predictor. Directed
// edge values, perfect numbers and square cofactors come first. Random
// traffic follows under four mixes of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;
  import pds_pkg::*;

  localparam int NUM_W = NUMBER_BITS_DEF;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_BITS) - 64'd1;
  // The watchdog limit leaves room for the largest 31-bit number on its own.
  localparam int QUIET_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SUM_BITS-1:0] aliquot_sum;
    logic                perfect_flag;
  } aliquot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [NUM_W-1:0]    in_number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SUM_BITS-1:0] out_aliquot_sum;
  logic                out_perfect_flag;

  aliquot_t expected_sums[$];
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int numbers_sent = 0;
  int sums_checked = 0;
  int perfect_seen = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  proper_divisor_sum #(
    .NUMBER_BITS(NUM_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_number       (in_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_aliquot_sum (out_aliquot_sum),
    .out_perfect_flag(out_perfect_flag)
  );

  // Aliquot sum by trial division up to the square root of the number.
  function automatic aliquot_t aliquot_of(input logic [NUM_W-1:0] number);
    longint unsigned num;
    longint unsigned acc;
    longint unsigned d;
    longint unsigned co;
    aliquot_t res;
    num = 64'(number);
    acc = 0;
    if (num >= 2) begin
      acc = 1;
      for (d = 2; d <= num / d; d++) begin
        if (num % d == 0) begin
          co = num / d;
          acc += d;
          if (co != d) acc += co;
        end
      end
      // The sum only grows, so clamping once equals saturating every add.
      if (acc > SUM_MAX) acc = SUM_MAX;
    end
    res.aliquot_sum  = acc[SUM_BITS-1:0];
    res.perfect_flag = (num >= 2) && (acc == num);
    return res;
  endfunction

  // Receiver: stall at random with the current percentage.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result checking, prediction on each input transfer, and the watchdog.
  always @(posedge clk) begin : check_results
    aliquot_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sums_checked++;
        if (out_perfect_flag) perfect_seen++;
        if (expected_sums.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: sum %0d perfect %0b",
                     out_aliquot_sum, out_perfect_flag);
        end else begin
          want = expected_sums.pop_front();
          if (out_aliquot_sum !== want.aliquot_sum ||
              out_perfect_flag !== want.perfect_flag) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result %0d: expected sum %0d perfect %0b, got sum %0d perfect %0b",
                       sums_checked, want.aliquot_sum, want.perfect_flag,
                       out_aliquot_sum, out_perfect_flag);
          end
        end
      end
      if (in_valid && !in_stall) expected_sums.push_back(aliquot_of(in_number));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Sends one number; valid stays high afterwards unless the next call idles.
  task automatic send_number(input logic [NUM_W-1:0] number);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= number;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    numbers_sent++;
  endtask

  // Zero and one, two to five, a prime and a power of two near 2^16,
  // and the all-ones maximum (a prime, so no divisor is found below its root).
  task automatic test_edge_values();
    logic [NUM_W-1:0] vals [9];
    vals = '{0, 1, 2, 3, 4, 5, 65521, 65536, 31'h7FFF_FFFF};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  // Perfect numbers, plus abundant ones whose sum overshoots the number.
  task automatic test_perfect_numbers();
    logic [NUM_W-1:0] vals [7];
    vals = '{6, 28, 496, 8128, 12, 120, 945};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  // Squares, where the root divisor must not be added twice, and 720720.
  task automatic test_square_cofactors();
    logic [NUM_W-1:0] vals [5];
    vals = '{9, 16, 36, 49, 720720};
    foreach (vals[i]) send_number(vals[i]);
  endtask

  // Random numbers kept mostly small so that each item stays short.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int               sel;
    int unsigned      root;
    logic [NUM_W-1:0] number;
    sender_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        number = NUM_W'($urandom_range(4095, 2));
      end else if (sel < 65) begin
        number = NUM_W'($urandom_range(65535, 4096));
      end else if (sel < 80) begin
        root   = $urandom_range(255, 2);
        number = NUM_W'(root * root);
      end else if (sel < 90) begin
        number = NUM_W'($urandom_range(200, 2) * $urandom_range(200, 2));
      end else if (sel < 96) begin
        case ($urandom_range(3))
          0: number = 6;
          1: number = 28;
          2: number = 496;
          default: number = 8128;
        endcase
      end else begin
        number = NUM_W'($urandom_range(1, 0));
      end
      send_number(number);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_perfect_numbers();
    test_square_cofactors();
    test_random_traffic(25, 0, 0);
    test_random_traffic(25, 88, 0);
    test_random_traffic(25, 0, 88);
    test_random_traffic(25, 14, 14);
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays.
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d numbers and checked %0d results (%0d perfect), %0d mismatches.",
             numbers_sent, sums_checked, perfect_seen, mismatch_count);
    $display("Covered zero/one, primes, squares, perfect numbers, the 31-bit maximum,");
    $display("and random traffic with no idling, sender gaps, receiver stalls and both.");
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
